// ===== hw/rtl/b64enc_pkg.sv =====
// Shared types, constants and the sextet-to-character map for the Base64 encoder.
`timescale 1ns / 1ps
`default_nettype none

package b64enc_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [6:0] PAD_CHAR   = 7'h3D;  // '='
    localparam logic [6:0] PLUS_CHAR  = 7'h2B;  // '+'
    localparam logic [6:0] SLASH_CHAR = 7'h2F;  // '/'

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_final;
    } in_item_t;

    typedef struct packed {
        logic [6:0] out_char;
        logic       end_of_text;
    } out_item_t;

    // One accepted byte worth of characters, handed from front to back.
    typedef struct packed {
        logic [3:0][6:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } job_t;

    typedef enum logic [2:0] {
        PH_ZERO = 3'b001,
        PH_ONE  = 3'b010,
        PH_TWO  = 3'b100
    } phase_t;

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26)
        begin
            c = 7'h41 + {1'b0, v};
        end
        else if (v < 6'd52)
        begin
            c = 7'd71 + {1'b0, v};
        end
        else if (v < 6'd62)
        begin
            c = {1'b0, v} - 7'd4;
        end
        else if (v == 6'd62)
        begin
            c = PLUS_CHAR;
        end
        else
        begin
            c = SLASH_CHAR;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/b64enc_front.sv =====
// Front end: tracks the group position and turns each byte into a character job.
`timescale 1ns / 1ps
`default_nettype none

module b64enc_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire logic                 full,
    input  wire b64enc_pkg::in_item_t data,
    output logic                      job_wr,
    output b64enc_pkg::job_t          job
);
    import b64enc_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [5:0] leftover_reg, leftover_next;
    logic [7:0] b;
    logic [5:0] lo;

    assign job_wr = push && !full;
    assign b      = data.data_byte;

    always_comb
    begin
        job.chars    = {4{PAD_CHAR}};
        job.last_idx = 2'd0;
        job.fin      = data.is_final;
        lo           = 6'd0;
        phase_next   = PH_ZERO;
        unique case (phase_reg)
            PH_ONE:
            begin
                lo            = {b[3:0], 2'b00};
                job.chars[0]  = sextet_char(leftover_reg | {2'b00, b[7:4]});
                job.chars[1]  = sextet_char(lo);
                job.last_idx  = data.is_final ? 2'd2 : 2'd0;
                phase_next    = PH_TWO;
            end
            PH_TWO:
            begin
                job.chars[0]  = sextet_char(leftover_reg | {4'b0000, b[7:6]});
                job.chars[1]  = sextet_char(b[5:0]);
                job.last_idx  = 2'd1;
                phase_next    = PH_ZERO;
            end
            default:
            begin
                lo            = {b[1:0], 4'b0000};
                job.chars[0]  = sextet_char(b[7:2]);
                job.chars[1]  = sextet_char(lo);
                job.last_idx  = data.is_final ? 2'd3 : 2'd0;
                phase_next    = PH_ONE;
            end
        endcase
        leftover_next = lo;
        // drop back to the start of a group after the last byte
        if (data.is_final)
        begin
            phase_next    = PH_ZERO;
            leftover_next = 6'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_ZERO;
            leftover_reg <= 6'd0;
        end
        else if (job_wr)
        begin
            phase_reg    <= phase_next;
            leftover_reg <= leftover_next;
        end
    end

    a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
        job_wr && data.is_final |=> phase_reg == PH_ZERO && leftover_reg == 6'd0)
        else $error("group state not cleared after final byte");

    a_zero_no_leftover: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ZERO |-> leftover_reg == 6'd0)
        else $error("leftover bits held at start of group");

    a_two_emits_pair: assert property (@(posedge clk) disable iff (!rst_n)
        job_wr && phase_reg == PH_TWO |-> job.last_idx == 2'd1)
        else $error("third byte of group must give two characters");

endmodule

`default_nettype wire

// ===== hw/rtl/b64enc_queue.sv =====
// Short job queue between front and back, show-ahead read.
`timescale 1ns / 1ps
`default_nettype none

module b64enc_queue #(
    parameter int DEPTH = b64enc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire b64enc_pkg::job_t wr_job,
    output logic                  full,
    input  wire logic             rd_en,
    output logic                  rd_valid,
    output b64enc_pkg::job_t      rd_job
);
    import b64enc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == FULL_CNT);
    assign rd_valid = (count_reg != '0);
    assign rd_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> count_reg != '0)
        else $error("job queue read while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> count_reg != FULL_CNT)
        else $error("job queue written while full");

    a_count_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en && !rd_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("job queue count lost a write");

endmodule

`default_nettype wire

// ===== hw/rtl/b64enc_back.sv =====
// Back end: walks each job one character per cycle into the output register while it is free.
`timescale 1ns / 1ps
`default_nettype none

module b64enc_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  wire b64enc_pkg::job_t q_job,
    output logic                  q_pop,
    output logic                  empty,
    input  wire logic             pop,
    output b64enc_pkg::out_item_t result
);
    import b64enc_pkg::*;

    job_t      job_reg;
    logic      job_valid_reg, job_valid_next;
    logic [1:0] idx_reg, idx_next;
    out_item_t out_reg;
    logic      out_valid_reg, out_valid_next;
    logic      out_load, job_done, at_last;

    assign at_last  = (idx_reg == job_reg.last_idx);
    assign out_load = job_valid_reg && (!out_valid_reg || pop);
    assign job_done = out_load && at_last;
    assign q_pop    = q_valid && (!job_valid_reg || job_done);

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        if (q_pop)
        begin
            job_valid_next = 1'b1;
            idx_next       = 2'd0;
        end
        else if (job_done)
        begin
            job_valid_next = 1'b0;
        end
        else if (out_load)
        begin
            idx_next = idx_reg + 1'b1;
        end

        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (out_load)
        begin
            out_reg.out_char    <= job_reg.chars[idx_reg];
            out_reg.end_of_text <= job_reg.fin && at_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> idx_reg <= job_reg.last_idx)
        else $error("character index past end of job");

    a_pop_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> job_valid_reg && idx_reg == 2'd0)
        else $error("new job did not start at first character");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |=> out_valid_reg && $stable(out_reg))
        else $error("waiting character changed or dropped");

endmodule

`default_nettype wire

// ===== hw/rtl/base64_stream_encoder.sv =====
// An accepted byte goes through the job queue and the job register to the output
// register. Throughput: one byte per cycle while the job queue has room; the output
// side gives one character per cycle while pop keeps up, so the sustained rate is
// four characters per three bytes.
// Reset: rst_n clears the group position, the job queue and both output stages.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = b64enc_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    output logic                       full,
    input  wire b64enc_pkg::in_item_t  data,
    output logic                       empty,
    input  wire logic                  pop,
    output b64enc_pkg::out_item_t      result
);
    import b64enc_pkg::*;

    logic job_wr;
    job_t job_in;
    logic q_valid;
    logic q_pop;
    job_t q_job;

    b64enc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .data   (data),
        .job_wr (job_wr),
        .job    (job_in)
    );

    b64enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (job_wr),
        .wr_job   (job_in),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_job   (q_job)
    );

    b64enc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

`default_nettype wire
